// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Next-cycle implication that also covers reset itself.
`define ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset check");

`endif

// ----- rtl/bdclp_pkg.sv -----
// Types and constants for the button debounce / click / long-press block.
package bdclp_pkg;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    REG_BUTTON_MASK   = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_DOUBLE_CLICK  = 3'd3,
    REG_DOUBLE_ENABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] double_click_ticks;
    logic        double_click_enable;
  } cfg_t;

  localparam logic [15:0] RST_BUTTON_MASK   = 16'd1;
  localparam logic [15:0] RST_DEBOUNCE      = 16'd50;
  localparam logic [15:0] RST_LONG_PRESS    = 16'd1000;
  localparam logic [15:0] RST_DOUBLE_CLICK  = 16'd300;
  localparam logic        RST_DOUBLE_ENABLE = 1'b0;

  localparam logic [7:0]  CLICK_MAX = 8'd255;

endpackage

// ----- rtl/bdclp_core.sv -----
// Debounce, press timing and click/long event state for the one combined button level.
module bdclp_core import bdclp_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] now,
  input  cfg_t                  cfg,
  output ev_t                   ev
);

  localparam int CW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

  logic                  raw_prev;
  logic [TIME_WIDTH-1:0] debounce_start, debounce_start_next;
  logic                  steady, steady_next;
  logic [TIME_WIDTH-1:0] press_start, press_start_next;
  logic                  long_fired, long_fired_next;
  logic [7:0]            click_count, click_count_next;
  logic [TIME_WIDTH-1:0] last_click, last_click_next;

  logic [TIME_WIDTH-1:0] db_el, long_el, gap_el;

  always_comb begin
    debounce_start_next = (level != raw_prev) ? now : debounce_start;
    steady_next         = steady;
    press_start_next    = press_start;
    long_fired_next     = long_fired;
    click_count_next    = click_count;
    last_click_next     = last_click;
    ev                  = EV_NONE;

    db_el = now - debounce_start_next;
    if ((CW'(db_el) > CW'(cfg.debounce_ticks)) && (level != steady)) begin
      steady_next = level;
      if (level) begin
        press_start_next = now;
        long_fired_next  = 1'b0;
      end else if (!long_fired) begin
        if (click_count != CLICK_MAX) begin
          click_count_next = 8'(click_count + 8'd1);
        end
        last_click_next = now;
      end
    end

    long_el = now - press_start_next;
    if (steady_next && !long_fired_next &&
        (CW'(long_el) > CW'(cfg.long_press_ticks))) begin
      long_fired_next  = 1'b1;
      click_count_next = 8'd0;
      ev               = EV_LONG;
    end

    gap_el = now - last_click_next;
    if (!steady_next && (click_count_next != 8'd0)) begin
      if (cfg.double_click_enable) begin
        if (CW'(gap_el) > CW'(cfg.double_click_ticks)) begin
          ev               = (click_count_next == 8'd1) ? EV_SINGLE : EV_DOUBLE;
          click_count_next = 8'd0;
        end
      end else begin
        ev               = EV_SINGLE;
        click_count_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev       <= 1'b0;
      debounce_start <= '0;
      steady         <= 1'b0;
      press_start    <= '0;
      long_fired     <= 1'b0;
      click_count    <= 8'd0;
      last_click     <= '0;
    end else if (fire) begin
      raw_prev       <= level;
      debounce_start <= debounce_start_next;
      steady         <= steady_next;
      press_start    <= press_start_next;
      long_fired     <= long_fired_next;
      click_count    <= click_count_next;
      last_click     <= last_click_next;
    end
  end

endmodule

// ----- rtl/button_debounce_click_long_press.sv -----
// Top level: button debounce with single, double and long-press events.
// Path: an accepted request passes through the input register, then the result register.
// Throughput: 1 request per cycle unless the result side stalls; the event state updates in a single pass.
// Reset: synchronous, clears handshake and event state, loads register defaults.
// Every accepted request yields exactly one result, EV_NONE included.
module button_debounce_click_long_press import bdclp_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] buttons,
  input  logic [31:0] timestamp,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res
);

  // Configuration registers.
  logic [15:0] button_mask;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_mask             <= RST_BUTTON_MASK;
      cfg.debounce_ticks      <= RST_DEBOUNCE;
      cfg.long_press_ticks    <= RST_LONG_PRESS;
      cfg.double_click_ticks  <= RST_DOUBLE_CLICK;
      cfg.double_click_enable <= RST_DOUBLE_ENABLE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_BUTTON_MASK:   button_mask             <= cfg_data;
        REG_DEBOUNCE:      cfg.debounce_ticks      <= cfg_data;
        REG_LONG_PRESS:    cfg.long_press_ticks    <= cfg_data;
        REG_DOUBLE_CLICK:  cfg.double_click_ticks  <= cfg_data;
        REG_DOUBLE_ENABLE: cfg.double_click_enable <= cfg_data[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Input register. It moves into the result register whenever that one is
  // empty or being drained, so a request enters every cycle unless the
  // result side holds back.
  logic        s1_valid;
  logic [15:0] s1_buttons;
  logic [31:0] s1_time;
  logic        accept, fire;

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_buttons <= buttons;
      s1_time    <= timestamp;
    end
  end

  // Timestamp folded to the internal time width.
  logic [TIME_WIDTH-1:0] now;

  generate
    if (TIME_WIDTH <= 32) begin : g_time_trunc
      assign now = s1_time[TIME_WIDTH-1:0];
    end else begin : g_time_ext
      assign now = {{(TIME_WIDTH-32){1'b0}}, s1_time};
    end
  endgenerate

  // Any selected bit pressed counts as the raw level; empty mask reads 0.
  logic level;
  assign level = |(s1_buttons & button_mask);

  ev_t ev;

  bdclp_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .level (level),
    .now   (now),
    .cfg   (cfg),
    .ev    (ev)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res <= ev;
    end
  end

endmodule

// ----- rtl/bdclp_checker.sv -----
// Port-level checker for the button event block, with its bind.
`include "assert_macros.svh"

module bdclp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] event_res
);

  // Reset empties both stages.
  `ASSERT_RST(a_reset_empty, rst, !out_valid && !in_stall)

  // With the result stage empty, nothing can push back on requests.
  `ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

  // A held result stage, with a request accepted meanwhile, must keep its result valid.
  `ASSERT_NEXT(a_stall_holds, out_valid && out_stall && in_valid && !in_stall, out_valid)

  // A stalled result stays put.
  `ASSERT_NEXT(a_result_stable, out_valid && out_stall, out_valid && $stable(event_res))

endmodule

bind button_debounce_click_long_press bdclp_checker u_bdclp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .event_res (event_res)
);
